// File: design/solar_heater_hysteresis_controller_macros.svh
// ----------------------------------------------------------------------------
// Solar heater controller assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOLAR_HEATER_HYSTERESIS_CONTROLLER_MACROS_SVH
`define SOLAR_HEATER_HYSTERESIS_CONTROLLER_MACROS_SVH

// Check cons in the same cycle as ante
`define SHC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shc same-cycle check failed");

// Check cons in the cycle after ante
`define SHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shc next-cycle check failed");

`endif

// File: design/shc_pkg.sv
// ----------------------------------------------------------------------------
// shc_pkg
// Types, widths and constants shared by the solar heater controller.
// ----------------------------------------------------------------------------
package shc_pkg;

  // Field widths
  localparam int LEVEL_W    = 12;
  localparam int TEMP_W     = 15;
  localparam int LTGT_W     = 10;
  localparam int TTGT_W     = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int MASK_W     = 5;
  // Signed width that holds every scaled product without overflow
  localparam int PROD_W     = 24;

  typedef logic signed [PROD_W-1:0] prod_t;

  // Band scale factors (percent, or half-percent for the outlet close band)
  localparam prod_t K99  = prod_t'(99);
  localparam prod_t K100 = prod_t'(100);
  localparam prod_t K101 = prod_t'(101);
  localparam prod_t K102 = prod_t'(102);
  localparam prod_t K199 = prod_t'(199);
  localparam prod_t K200 = prod_t'(200);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_TARGET  = 8'd0,
    REG_LEVEL_ENABLE  = 8'd1,
    REG_BOILER_TARGET = 8'd2,
    REG_BOILER_ENABLE = 8'd3,
    REG_PIPE_TARGET   = 8'd4,
    REG_PIPE_ENABLE   = 8'd5
  } reg_idx_t;

  // Actuator flags, bit 0 is the inlet valve
  typedef struct packed {
    logic recirc;
    logic heater;
    logic collector;
    logic outlet;
    logic inlet;
  } flags_t;

  // One sensor sample
  typedef struct packed {
    logic        [LEVEL_W-1:0] level_mm;
    logic signed [TEMP_W-1:0]  boiler_temp;
    logic signed [TEMP_W-1:0]  pipe_temp;
    logic signed [TEMP_W-1:0]  collector_temp;
  } sample_t;

  // Loop setpoints and enables
  typedef struct packed {
    logic [LTGT_W-1:0] level_target;
    logic              level_enable;
    logic [TTGT_W-1:0] boiler_target;
    logic              boiler_enable;
    logic [TTGT_W-1:0] pipe_target;
    logic              pipe_enable;
  } cfg_t;

  // Widen an unsigned level to the product width
  function automatic prod_t widen_level(input logic [LEVEL_W-1:0] v);
    return prod_t'({{(PROD_W-LEVEL_W){1'b0}}, v});
  endfunction

  // Widen an unsigned target to the product width
  function automatic prod_t widen_target(input logic [TTGT_W-1:0] v);
    return prod_t'({{(PROD_W-TTGT_W){1'b0}}, v});
  endfunction

  // Sign-extend a temperature to the product width
  function automatic prod_t widen_temp(input logic [TEMP_W-1:0] v);
    return prod_t'({{(PROD_W-TEMP_W){v[TEMP_W-1]}}, v});
  endfunction

endpackage

// File: design/shc_decide.sv
// ----------------------------------------------------------------------------
// shc_decide
// Hysteresis decisions for the level, boiler and pipe loops of one sample.
// ----------------------------------------------------------------------------
module shc_decide (
  input  shc_pkg::sample_t              sample,
  input  shc_pkg::cfg_t                 cfg,
  input  shc_pkg::flags_t               flags_cur,
  output shc_pkg::flags_t               flags_nxt,
  output logic [shc_pkg::MASK_W-1:0]    mask_nxt
);

  shc_pkg::prod_t lvl, bt, pt, ct, lt, btg, ptg;
  logic inlet_on_c, inlet_off_c, outlet_on_c, outlet_off_c;
  logic boil_low_c, boil_high_c, coll_hot_c;
  logic pipe_low_c, pipe_high_c, boil_hot_c;

  // Widen operands
  assign lvl = shc_pkg::widen_level(sample.level_mm);
  assign bt  = shc_pkg::widen_temp(sample.boiler_temp);
  assign pt  = shc_pkg::widen_temp(sample.pipe_temp);
  assign ct  = shc_pkg::widen_temp(sample.collector_temp);
  assign lt  = shc_pkg::widen_target({{(shc_pkg::TTGT_W-shc_pkg::LTGT_W){1'b0}},
                                      cfg.level_target});
  assign btg = shc_pkg::widen_target(cfg.boiler_target);
  assign ptg = shc_pkg::widen_target(cfg.pipe_target);

  // Level bands
  assign inlet_on_c   = (lvl * shc_pkg::K100) < (lt * shc_pkg::K99);
  assign inlet_off_c  = (lvl * shc_pkg::K100) > (lt * shc_pkg::K101);
  assign outlet_on_c  = (lvl * shc_pkg::K100) > (lt * shc_pkg::K102);
  assign outlet_off_c = (lvl * shc_pkg::K200) < (lt * shc_pkg::K199);

  // Boiler bands and collector gain
  assign boil_low_c  = (bt * shc_pkg::K100) < (btg * shc_pkg::K99);
  assign boil_high_c = (bt * shc_pkg::K100) > (btg * shc_pkg::K101);
  assign coll_hot_c  = (ct * shc_pkg::K100) > (bt * shc_pkg::K101);

  // Pipe bands and boiler gain
  assign pipe_low_c  = (pt * shc_pkg::K100) < (ptg * shc_pkg::K99);
  assign pipe_high_c = (pt * shc_pkg::K100) > (ptg * shc_pkg::K101);
  assign boil_hot_c  = (bt * shc_pkg::K100) > (pt * shc_pkg::K101);

  // Apply each enabled loop; hold flags inside the band
  always_comb begin
    flags_nxt = flags_cur;
    mask_nxt  = '0;
    if (cfg.level_enable) begin
      if (inlet_on_c) begin
        flags_nxt.inlet = 1'b1;
        mask_nxt[0]     = 1'b1;
      end else if (inlet_off_c) begin
        flags_nxt.inlet = 1'b0;
        mask_nxt[0]     = 1'b1;
      end
      if (outlet_on_c) begin
        flags_nxt.outlet = 1'b1;
        mask_nxt[1]      = 1'b1;
      end else if (outlet_off_c) begin
        flags_nxt.outlet = 1'b0;
        mask_nxt[1]      = 1'b1;
      end
    end
    if (cfg.boiler_enable) begin
      if (boil_low_c) begin
        if (coll_hot_c) begin
          flags_nxt.collector = 1'b1;
          mask_nxt[2]         = 1'b1;
        end
        flags_nxt.heater = 1'b1;
        mask_nxt[3]      = 1'b1;
      end else if (boil_high_c) begin
        flags_nxt.collector = 1'b0;
        mask_nxt[2]         = 1'b1;
        flags_nxt.heater    = 1'b0;
        mask_nxt[3]         = 1'b1;
      end
    end
    if (cfg.pipe_enable) begin
      if (pipe_low_c) begin
        if (boil_hot_c) begin
          flags_nxt.recirc = 1'b1;
          mask_nxt[4]      = 1'b1;
        end
      end else if (pipe_high_c) begin
        flags_nxt.recirc = 1'b0;
        mask_nxt[4]      = 1'b1;
      end
    end
  end

endmodule

// File: design/solar_heater_hysteresis_controller.sv
// ----------------------------------------------------------------------------
// solar_heater_hysteresis_controller
// Bang-bang level and temperature control of a solar water heater.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sensor sample per transaction (level, boiler, pipe and
//            collector temperatures), valid/ready.
//   out_*  : one result per sample: five actuator states after the step and
//            a mask of the actuators commanded in that step, valid/ready.
//   cfg_*  : register writes (index, data), always ready; write only while
//            no sample is in flight.
//   Path: an accepted sample waits in the input register, then its decision
//   is captured in the result register (one input register, one result register).
//   Throughput: one sample per cycle while out_ready is high; the decision is
//   a single pass of constant multiplies and compares between the two registers.
//   Reset: all targets, enables and actuator flags clear to zero; no
//   transaction is pending.
//   Stall: while out_ready is low the result holds, the input register
//   still takes one more sample, then in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
`include "solar_heater_hysteresis_controller_macros.svh"

module solar_heater_hysteresis_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [shc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [shc_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Samples
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [shc_pkg::LEVEL_W-1:0]          in_level_mm,
  input  logic signed [shc_pkg::TEMP_W-1:0]    in_boiler_temp,
  input  logic signed [shc_pkg::TEMP_W-1:0]    in_pipe_temp,
  input  logic signed [shc_pkg::TEMP_W-1:0]    in_collector_temp,
  // Results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_inlet_on,
  output logic                                 out_outlet_on,
  output logic                                 out_collector_pump_on,
  output logic                                 out_heater_on,
  output logic                                 out_recirc_pump_on,
  output logic [shc_pkg::MASK_W-1:0]           out_command_mask
);

  shc_pkg::cfg_t    cfg_r;
  shc_pkg::sample_t sample_r;
  logic             sample_valid_r;
  shc_pkg::flags_t  flags_r, flags_nxt;
  logic [shc_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic             out_valid_r;
  logic             advance;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        shc_pkg::REG_LEVEL_TARGET:  cfg_r.level_target  <= cfg_data[shc_pkg::LTGT_W-1:0];
        shc_pkg::REG_LEVEL_ENABLE:  cfg_r.level_enable  <= cfg_data[0];
        shc_pkg::REG_BOILER_TARGET: cfg_r.boiler_target <= cfg_data[shc_pkg::TTGT_W-1:0];
        shc_pkg::REG_BOILER_ENABLE: cfg_r.boiler_enable <= cfg_data[0];
        shc_pkg::REG_PIPE_TARGET:   cfg_r.pipe_target   <= cfg_data[shc_pkg::TTGT_W-1:0];
        shc_pkg::REG_PIPE_ENABLE:   cfg_r.pipe_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Move the held sample into the result stage when that stage is free
  assign advance  = sample_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !sample_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_valid_r <= 1'b0;
    end else if (in_ready) begin
      sample_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r.level_mm       <= in_level_mm;
      sample_r.boiler_temp    <= in_boiler_temp;
      sample_r.pipe_temp      <= in_pipe_temp;
      sample_r.collector_temp <= in_collector_temp;
    end
  end

  // Loop decisions
  shc_decide u_decide (
    .sample    (sample_r),
    .cfg       (cfg_r),
    .flags_cur (flags_r),
    .flags_nxt (flags_nxt),
    .mask_nxt  (mask_nxt)
  );

  // Actuator state and result register; flags change only on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mask_r <= mask_nxt;
    end
  end

  // Drive result ports
  assign out_valid             = out_valid_r;
  assign out_inlet_on          = flags_r.inlet;
  assign out_outlet_on         = flags_r.outlet;
  assign out_collector_pump_on = flags_r.collector;
  assign out_heater_on         = flags_r.heater;
  assign out_recirc_pump_on    = flags_r.recirc;
  assign out_command_mask      = mask_r;

  // A flag only changes when its actuator was commanded
  `SHC_ASSERT_NEXT(a_flag_change_commanded, advance, ((flags_r ^ $past(flags_r)) & ~mask_r) == '0)
  // Disabled level loop commands neither valve
  `SHC_ASSERT_NEXT(a_level_idle, advance && !cfg_r.level_enable, mask_r[1:0] == 2'b00)
  // Collector pump is only switched on together with the heater
  `SHC_ASSERT_SAME(a_collector_with_heater, advance && mask_nxt[2] && flags_nxt.collector,
                   flags_nxt.heater && mask_nxt[3])
  // Inlet and outlet never both commanded open in one step
  `SHC_ASSERT_SAME(a_valves_exclusive, advance && mask_nxt[0] && mask_nxt[1],
                   !(flags_nxt.inlet && flags_nxt.outlet))

endmodule

// File: test/solar_heater_hysteresis_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// solar_heater_hysteresis_controller_tb
// Drives sensor samples and register writes into the hysteresis controller
// and checks every result against a cycle-free model of the three loops.
// A directed table covers band edges and extreme targets; random phases
// follow, with random backpressure, a long output stall and a quiet tail.
// ----------------------------------------------------------------------------
module solar_heater_hysteresis_controller_tb;

  localparam int LEVEL_W    = shc_pkg::LEVEL_W;
  localparam int TEMP_W     = shc_pkg::TEMP_W;
  localparam int LTGT_W     = shc_pkg::LTGT_W;
  localparam int TTGT_W     = shc_pkg::TTGT_W;
  localparam int CFG_IDX_W  = shc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = shc_pkg::CFG_DATA_W;
  localparam int MASK_W     = shc_pkg::MASK_W;

  localparam int NUM_PHASES      = 13;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_PHASE      = 2;
  localparam int LONG_HOLD       = 80;
  localparam int STALL_LIMIT     = 2000;

  // Indexes past the register file; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_BOGUS_LOW   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOGUS_ALIAS = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_BOGUS_TOP   = 8'hFF;

  localparam logic [CFG_DATA_W-1:0] DATA_ONES = '1;

  typedef enum {STEP_TYPED, STEP_PREDICTED, REG_WRITE} row_kind_t;

  // Actuator states after a step plus the actuators commanded in it
  typedef struct packed {
    shc_pkg::flags_t state;
    shc_pkg::flags_t cmd;
  } actuation_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    int                     level;
    int                     boiler;
    int                     pipe;
    int                     collector;
    shc_pkg::flags_t        state;
    shc_pkg::flags_t        cmd;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [LEVEL_W-1:0]       in_level_mm;
  logic signed [TEMP_W-1:0] in_boiler_temp;
  logic signed [TEMP_W-1:0] in_pipe_temp;
  logic signed [TEMP_W-1:0] in_collector_temp;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_inlet_on;
  logic                     out_outlet_on;
  logic                     out_collector_pump_on;
  logic                     out_heater_on;
  logic                     out_recirc_pump_on;
  logic [MASK_W-1:0]        out_command_mask;

  // Model state: loop settings and actuator flags
  shc_pkg::cfg_t   loop_cfg;
  shc_pkg::flags_t actuators;
  actuation_t      pending_actuations[$];

  int  samples_sent;
  int  results_checked;
  int  reg_writes;
  int  mismatches;
  int  quiet_cycles;
  int  hold_request;
  bit  rx_stall_en;
  bit  tx_gap_en;

  // Directed stimulus: writes, typed rows off the control rules, predicted rows
  dir_row_t dir_rows [0:32] = '{
    // Reset state: all loops idle, nothing commanded
    '{STEP_TYPED, '0, '0, 4095, 16383, -16384, 0, 5'b00000, 5'b00000},
    '{STEP_TYPED, '0, '0, 0, 0, 0, 0, 5'b00000, 5'b00000},
    '{REG_WRITE, shc_pkg::REG_LEVEL_TARGET, 13'd500, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, shc_pkg::REG_LEVEL_ENABLE, DATA_ONES, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, shc_pkg::REG_BOILER_TARGET, 13'd6000, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, shc_pkg::REG_BOILER_ENABLE, 13'd1, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, shc_pkg::REG_PIPE_TARGET, 13'd4000, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, shc_pkg::REG_PIPE_ENABLE, 13'd1, 0, 0, 0, 0, '0, '0},
    // Field extremes: low with a hot collector, high with a cold one, in band
    '{STEP_TYPED, '0, '0, 0, -16384, -16384, 16383, 5'b11101, 5'b11111},
    '{STEP_TYPED, '0, '0, 4095, 16383, 16383, -16384, 5'b00010, 5'b11111},
    '{STEP_TYPED, '0, '0, 500, 6000, 4000, 0, 5'b00010, 5'b00000},
    // Level band edges
    '{STEP_PREDICTED, '0, '0, 494, 6000, 4000, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 495, 6000, 4000, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 506, 6000, 4000, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 510, 6000, 4000, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 511, 6000, 4000, 0, '0, '0},
    // Collector just not hotter, then just hotter, then boiler too hot
    '{STEP_PREDICTED, '0, '0, 500, 5000, 4000, 5050, '0, '0},
    '{STEP_PREDICTED, '0, '0, 500, 5000, 4000, 5051, '0, '0},
    '{STEP_PREDICTED, '0, '0, 500, 6061, 4000, 0, '0, '0},
    // Recirculation: boiler just not hotter, just hotter, pipe too hot
    '{STEP_PREDICTED, '0, '0, 500, 3030, 3000, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 500, 3031, 3000, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 500, 6000, 4041, 0, '0, '0},
    // Oversized and zero targets; writes past the register file
    '{REG_WRITE, shc_pkg::REG_LEVEL_TARGET, DATA_ONES, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, shc_pkg::REG_BOILER_TARGET, 13'd0, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, shc_pkg::REG_PIPE_TARGET, DATA_ONES, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, REG_BOGUS_LOW, DATA_ONES, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, REG_BOGUS_ALIAS, 13'd0, 0, 0, 0, 0, '0, '0},
    '{REG_WRITE, REG_BOGUS_TOP, 13'd0, 0, 0, 0, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 1012, -1, 8000, 16383, '0, '0},
    '{STEP_PREDICTED, '0, '0, 4095, 0, 16383, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 4095, 1, 16383, 0, '0, '0},
    // Level loop off through an even data word
    '{REG_WRITE, shc_pkg::REG_LEVEL_ENABLE, 13'h1FFE, 0, 0, 0, 0, '0, '0},
    '{STEP_PREDICTED, '0, '0, 0, -16384, 0, 0, '0, '0}
  };

  solar_heater_hysteresis_controller uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_level_mm           (in_level_mm),
    .in_boiler_temp        (in_boiler_temp),
    .in_pipe_temp          (in_pipe_temp),
    .in_collector_temp     (in_collector_temp),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_inlet_on          (out_inlet_on),
    .out_outlet_on         (out_outlet_on),
    .out_collector_pump_on (out_collector_pump_on),
    .out_heater_on         (out_heater_on),
    .out_recirc_pump_on    (out_recirc_pump_on),
    .out_command_mask      (out_command_mask)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Update the model settings for one register write
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      shc_pkg::REG_LEVEL_TARGET:  loop_cfg.level_target  = data[LTGT_W-1:0];
      shc_pkg::REG_LEVEL_ENABLE:  loop_cfg.level_enable  = data[0];
      shc_pkg::REG_BOILER_TARGET: loop_cfg.boiler_target = data[TTGT_W-1:0];
      shc_pkg::REG_BOILER_ENABLE: loop_cfg.boiler_enable = data[0];
      shc_pkg::REG_PIPE_TARGET:   loop_cfg.pipe_target   = data[TTGT_W-1:0];
      shc_pkg::REG_PIPE_ENABLE:   loop_cfg.pipe_enable   = data[0];
      default: ;
    endcase
  endfunction

  // Run the three loops on one sample and advance the actuator flags
  function automatic actuation_t step_actuators(input shc_pkg::sample_t s);
    longint lv;
    longint bt;
    longint pt;
    longint ct;
    longint t;
    shc_pkg::flags_t cmd;
    lv  = longint'(s.level_mm);
    bt  = $signed(s.boiler_temp);
    pt  = $signed(s.pipe_temp);
    ct  = $signed(s.collector_temp);
    cmd = '0;
    if (loop_cfg.level_enable) begin
      t = longint'(loop_cfg.level_target);
      if (100 * lv < 99 * t) begin
        actuators.inlet = 1'b1;
        cmd.inlet = 1'b1;
      end else if (100 * lv > 101 * t) begin
        actuators.inlet = 1'b0;
        cmd.inlet = 1'b1;
      end
      if (100 * lv > 102 * t) begin
        actuators.outlet = 1'b1;
        cmd.outlet = 1'b1;
      end else if (200 * lv < 199 * t) begin
        actuators.outlet = 1'b0;
        cmd.outlet = 1'b1;
      end
    end
    if (loop_cfg.boiler_enable) begin
      t = longint'(loop_cfg.boiler_target);
      if (100 * bt < 99 * t) begin
        // Collector only helps when it is clearly hotter than the boiler
        if (100 * ct > 101 * bt) begin
          actuators.collector = 1'b1;
          cmd.collector = 1'b1;
        end
        actuators.heater = 1'b1;
        cmd.heater = 1'b1;
      end else if (100 * bt > 101 * t) begin
        actuators.collector = 1'b0;
        actuators.heater = 1'b0;
        cmd.collector = 1'b1;
        cmd.heater = 1'b1;
      end
    end
    if (loop_cfg.pipe_enable) begin
      t = longint'(loop_cfg.pipe_target);
      if (100 * pt < 99 * t) begin
        if (100 * bt > 101 * pt) begin
          actuators.recirc = 1'b1;
          cmd.recirc = 1'b1;
        end
      end else if (100 * pt > 101 * t) begin
        actuators.recirc = 1'b0;
        cmd.recirc = 1'b1;
      end
    end
    return {actuators, cmd};
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Value within a few percent of a center point, to land on band edges
  function automatic int near_value(input int center);
    int span;
    span = ((center < 0) ? -center : center) / 20 + 4;
    return center - span + int'($urandom_range(0, 2 * span));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_target(input int hi);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return DATA_ONES;
      2, 3:    return CFG_DATA_W'($urandom_range(0, hi));
      default: return CFG_DATA_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_enable();
    return {12'($urandom_range(0, 4095)), 1'($urandom_range(0, 3) != 0)};
  endfunction

  // Mostly samples near the targets, some anywhere in the field range
  function automatic shc_pkg::sample_t pick_sample();
    shc_pkg::sample_t s;
    int lv;
    int bv;
    int pv;
    int cv;
    int sel;
    if ($urandom_range(0, 3) != 0) lv = near_value(int'(loop_cfg.level_target));
    else lv = int'($urandom_range(0, 4095));
    if ($urandom_range(0, 3) != 0) pv = near_value(int'(loop_cfg.pipe_target));
    else pv = int'($urandom_range(0, 32767)) - 16384;
    sel = $urandom_range(0, 19);
    if (sel < 12) bv = near_value(int'(loop_cfg.boiler_target));
    else if (sel < 15) bv = near_value(pv);
    else bv = int'($urandom_range(0, 32767)) - 16384;
    if ($urandom_range(0, 4) < 3) cv = near_value(bv);
    else cv = int'($urandom_range(0, 32767)) - 16384;
    s.level_mm       = LEVEL_W'(clamp(lv, 0, 4095));
    s.boiler_temp    = TEMP_W'(clamp(bv, -16384, 16383));
    s.pipe_temp      = TEMP_W'(clamp(pv, -16384, 16383));
    s.collector_temp = TEMP_W'(clamp(cv, -16384, 16383));
    return s;
  endfunction

  // Offer one sample and hold it until accepted; valid stays high
  task automatic send_sample(input shc_pkg::sample_t s, input bit use_typed,
                             input actuation_t typed_val);
    actuation_t predicted;
    in_valid          <= 1'b1;
    in_level_mm       <= s.level_mm;
    in_boiler_temp    <= s.boiler_temp;
    in_pipe_temp      <= s.pipe_temp;
    in_collector_temp <= s.collector_temp;
    do @(posedge clk); while (!in_ready);
    predicted = step_actuators(s);
    pending_actuations.push_back(use_typed ? typed_val : predicted);
    samples_sent++;
  endtask

  // Issue one register write; the caller drops cfg_valid afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    reg_writes++;
  endtask

  task automatic wait_drained();
    while (pending_actuations.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [MASK_W-1:0] want,
                             input logic [MASK_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0b got %0b", $time, what, want, got);
    end
  endtask

  // Stimulus: reset, directed table, then random phases
  initial begin : stimulus
    shc_pkg::sample_t s;
    actuation_t       typed_val;
    int               phase;
    int               n;
    rst_n             <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    in_level_mm       <= '0;
    in_boiler_temp    <= '0;
    in_pipe_temp      <= '0;
    in_collector_temp <= '0;
    loop_cfg          = '0;
    actuators         = '0;
    hold_request      = 0;
    rx_stall_en       = 1'b1;
    tx_gap_en         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == REG_WRITE) begin
        in_valid <= 1'b0;
        wait_drained();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else begin
        cfg_valid <= 1'b0;
        s.level_mm       = LEVEL_W'(dir_rows[i].level);
        s.boiler_temp    = TEMP_W'(dir_rows[i].boiler);
        s.pipe_temp      = TEMP_W'(dir_rows[i].pipe);
        s.collector_temp = TEMP_W'(dir_rows[i].collector);
        typed_val = {dir_rows[i].state, dir_rows[i].cmd};
        send_sample(s, dir_rows[i].kind == STEP_TYPED, typed_val);
      end
    end

    // Random phases, each under fresh loop settings
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      in_valid <= 1'b0;
      wait_drained();
      if (phase == 0) begin
        write_reg(shc_pkg::REG_LEVEL_TARGET, DATA_ONES);
        write_reg(shc_pkg::REG_BOILER_TARGET, DATA_ONES);
        write_reg(shc_pkg::REG_PIPE_TARGET, DATA_ONES);
      end else if (phase == 1) begin
        write_reg(shc_pkg::REG_LEVEL_TARGET, '0);
        write_reg(shc_pkg::REG_BOILER_TARGET, '0);
        write_reg(shc_pkg::REG_PIPE_TARGET, '0);
      end else begin
        write_reg(shc_pkg::REG_LEVEL_TARGET, pick_target(600));
        write_reg(shc_pkg::REG_BOILER_TARGET, pick_target(8000));
        write_reg(shc_pkg::REG_PIPE_TARGET, pick_target(8000));
      end
      if (phase < 2) begin
        write_reg(shc_pkg::REG_LEVEL_ENABLE, 13'd1);
        write_reg(shc_pkg::REG_BOILER_ENABLE, 13'd1);
        write_reg(shc_pkg::REG_PIPE_ENABLE, 13'd1);
      end else begin
        write_reg(shc_pkg::REG_LEVEL_ENABLE, pick_enable());
        write_reg(shc_pkg::REG_BOILER_ENABLE, pick_enable());
        write_reg(shc_pkg::REG_PIPE_ENABLE, pick_enable());
      end
      if (phase % 2 == 1)
        write_reg(CFG_IDX_W'($urandom_range(6, 255)), CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;

      // Idling per phase: long output stall, clean stretches, quiet tail
      rx_stall_en = !(phase == HOLD_PHASE || phase == 3 || phase == NUM_PHASES - 1);
      tx_gap_en   = rx_stall_en;
      if (phase == HOLD_PHASE) hold_request = LONG_HOLD;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(pick_sample(), 1'b0, '0);
        if (n == ITEMS_PER_PHASE / 2 && phase % 4 == 1) begin
          // Pause the sender until the pipeline is empty
          in_valid <= 1'b0;
          wait_drained();
        end else if (tx_gap_en && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
      end
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d samples (%0d checked), %0d register writes, %0d random phases",
             samples_sent, results_checked, reg_writes, NUM_PHASES);
    $display("Covered band edges, odd targets, disabled loops, bad indexes and stalls");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result receiver: random stall bursts, one long hold on request
  initial begin : receiver
    int hold;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    actuation_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_actuations.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got mask %0b", $time, out_command_mask);
      end else begin
        want = pending_actuations.pop_front();
        results_checked++;
        check_field("inlet_on", want.state.inlet, out_inlet_on);
        check_field("outlet_on", want.state.outlet, out_outlet_on);
        check_field("collector_pump_on", want.state.collector, out_collector_pump_on);
        check_field("heater_on", want.state.heater, out_heater_on);
        check_field("recirc_pump_on", want.state.recirc, out_recirc_pump_on);
        check_field("command_mask", want.cmd, out_command_mask);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Timeout: %0d results still pending", pending_actuations.size());
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
